// ===== rtl/wofc_pkg.sv =====
// Shared types and constants of the write-once file allocation chain engine.
// Used by every module of the block; depends on nothing.
package wofc_pkg;

  localparam int unsigned SECT_W    = 8;
  localparam int unsigned ALLOC_W   = 9;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned BPS_W     = 17;
  localparam int unsigned PROD_W    = SECT_W + BPS_W;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned DIR_DEPTH = 256;

  localparam logic [SECT_W-1:0] END_MARK   = 8'hFF;
  localparam logic [SECT_W-1:0] LAST_ENTRY = 8'hFE;

  localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0002_0000;
  localparam logic [BPS_W-1:0]  BPS_RESET  = 17'h0_0200;

  localparam logic [1:0] REQ_NEW_FILE  = 2'd0;
  localparam logic [1:0] REQ_FILE_SIZE = 2'd1;
  localparam logic [1:0] REQ_APPEND    = 2'd2;
  localparam logic [1:0] REQ_LOCATE    = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NO_DATA = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DISK_BASE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_BYTES = 1'b1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [SECT_W-1:0] file_number;
    logic [SECT_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SECT_W-1:0] free_entry;
    logic [SECT_W-1:0] size_sectors;
    logic [SECT_W-1:0] sector_number;
    logic [ADDR_W-1:0] sector_address;
  } result_t;

  localparam result_t RESULT_IDLE = '{
    status:         STATUS_OK,
    free_entry:     END_MARK,
    size_sectors:   '0,
    sector_number:  END_MARK,
    sector_address: '0
  };

  typedef struct packed {
    logic [SECT_W-1:0]  dir_rd_addr;
    logic               dir_wr_en;
    logic [SECT_W-1:0]  dir_wr_addr;
    logic [SECT_W-1:0]  dir_wr_data;
    logic [SECT_W-1:0]  link_rd_addr;
    logic               link_wr_en;
    logic [SECT_W-1:0]  link_wr_addr;
    logic [SECT_W-1:0]  link_wr_data;
    logic [SECT_W-1:0]  scan_addr;
    logic [ALLOC_W-1:0] fill;
  } tbl_req_t;

  typedef struct packed {
    logic [SECT_W-1:0] dir_data;
    logic [SECT_W-1:0] link_data;
  } tbl_rsp_t;

endpackage

// ===== rtl/wofc_tables.sv =====
// Directory and link memories with registered reads.
// Depends on wofc_pkg; unwritten entries read as the end marker.
module wofc_tables
  import wofc_pkg::*;
#(
  parameter int unsigned SECTOR_COUNT = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  tbl_req_t tq,
  output tbl_rsp_t tr,
  output logic     scan_used
);

  localparam int unsigned LINK_IDX_W = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;

  logic [SECT_W-1:0]    dir_mem  [DIR_DEPTH];
  logic [SECT_W-1:0]    link_mem [SECTOR_COUNT];
  logic [DIR_DEPTH-1:0] dir_used;
  logic [SECT_W-1:0]    dir_q;
  logic [SECT_W-1:0]    link_q;
  logic                 dir_ok;
  logic                 link_ok;

  always_ff @(posedge clk) begin
    if (tq.dir_wr_en) begin
      dir_mem[tq.dir_wr_addr] <= tq.dir_wr_data;
    end
    dir_q <= dir_mem[tq.dir_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (tq.link_wr_en) begin
      link_mem[tq.link_wr_addr[LINK_IDX_W-1:0]] <= tq.link_wr_data;
    end
    link_q <= link_mem[tq.link_rd_addr[LINK_IDX_W-1:0]];
  end

  // A link entry holds data only once its sector has been handed out.
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_used <= '0;
      dir_ok   <= 1'b0;
      link_ok  <= 1'b0;
    end else begin
      if (tq.dir_wr_en) begin
        dir_used[tq.dir_wr_addr] <= 1'b1;
      end
      dir_ok  <= dir_used[tq.dir_rd_addr];
      link_ok <= ({1'b0, tq.link_rd_addr} < tq.fill);
    end
  end

  assign tr.dir_data  = dir_ok ? dir_q : END_MARK;
  assign tr.link_data = link_ok ? link_q : END_MARK;
  assign scan_used    = dir_used[tq.scan_addr];

endmodule

// ===== rtl/wofc_addr.sv =====
// Two-stage sector address unit: multiply by the sector size, then add the base.
// Depends on wofc_pkg.
module wofc_addr
  import wofc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [SECT_W-1:0] sector,
  input  logic [ADDR_W-1:0] base,
  input  logic [BPS_W-1:0]  bps,
  output logic              valid,
  output logic [ADDR_W-1:0] addr
);

  logic [PROD_W-1:0] prod;
  logic              prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      valid      <= 1'b0;
    end else begin
      prod_valid <= go;
      valid      <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= {{BPS_W{1'b0}}, sector} * {{SECT_W{1'b0}}, bps};
    addr <= base + {{(ADDR_W-PROD_W){1'b0}}, prod};
  end

endmodule

// ===== rtl/write_once_fat_chain_engine.sv =====
// Write-once file allocation chain engine, top level; uses wofc_pkg, wofc_tables, wofc_addr.
// One item at a time. new_file checks one directory entry per cycle until one is free.
// file_size walks the chain of a file, locate walks it up to position P and append walks
// it to its end, one link read per cycle; append stops early when the disk is full. A
// returned sector then passes through the address arithmetic. Each result is shown for one
// cycle on done. Synchronous reset empties both tables and resets base and sector size.
module write_once_fat_chain_engine
  import wofc_pkg::*;
#(
  parameter int unsigned SECTOR_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam logic [ALLOC_W-1:0] USABLE =
    ALLOC_W'((SECTOR_COUNT > 255) ? 255 : SECTOR_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_HEAD,
    S_WALK,
    S_TERM,
    S_CALC,
    S_WAIT
  } state_t;

  state_t             state;
  req_t               req_q;
  result_t            res;
  logic [SECT_W-1:0]  cur;
  logic [SECT_W-1:0]  remain;
  logic [SECT_W-1:0]  count;
  logic [SECT_W-1:0]  scan_idx;
  logic [ALLOC_W-1:0] alloc;
  logic [ADDR_W-1:0]  base;
  logic [BPS_W-1:0]   bps;
  logic [SECT_W-1:0]  fresh;
  logic               addr_valid;
  logic [ADDR_W-1:0]  addr;
  logic               scan_used;
  tbl_req_t           tq;
  tbl_rsp_t           tr;

  assign fresh  = alloc[SECT_W-1:0];
  assign busy   = (state != S_IDLE);
  assign result = res;

  wofc_tables #(
    .SECTOR_COUNT(SECTOR_COUNT)
  ) u_tables (
    .clk      (clk),
    .rst      (rst),
    .tq       (tq),
    .tr       (tr),
    .scan_used(scan_used)
  );

  wofc_addr u_addr (
    .clk   (clk),
    .rst   (rst),
    .go    (state == S_CALC),
    .sector(res.sector_number),
    .base  (base),
    .bps   (bps),
    .valid (addr_valid),
    .addr  (addr)
  );

  always_comb begin
    tq              = '0;
    tq.dir_rd_addr  = req_q.file_number;
    tq.scan_addr    = scan_idx;
    tq.fill         = alloc;
    tq.link_rd_addr = tr.link_data;
    if (state == S_HEAD) begin
      tq.link_rd_addr = tr.dir_data;
      if (req_q.req_type == REQ_APPEND && tr.dir_data == END_MARK) begin
        tq.dir_wr_en    = 1'b1;
        tq.dir_wr_addr  = req_q.file_number;
        tq.dir_wr_data  = fresh;
        tq.link_wr_en   = 1'b1;
        tq.link_wr_addr = fresh;
        tq.link_wr_data = END_MARK;
      end
    end
    if (state == S_WALK && req_q.req_type == REQ_APPEND && tr.link_data == END_MARK) begin
      tq.link_wr_en   = 1'b1;
      tq.link_wr_addr = cur;
      tq.link_wr_data = fresh;
    end
    if (state == S_TERM) begin
      tq.link_wr_en   = 1'b1;
      tq.link_wr_addr = fresh;
      tq.link_wr_data = END_MARK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      alloc <= '0;
      base  <= BASE_RESET;
      bps   <= BPS_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_DISK_BASE:    base <= cfg_data;
          REG_SECTOR_BYTES: bps  <= cfg_data[BPS_W-1:0];
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_q <= req;
            res   <= RESULT_IDLE;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (req_q.req_type)
            REQ_NEW_FILE: begin
              scan_idx <= '0;
              state    <= S_SCAN;
            end
            REQ_APPEND: begin
              if (alloc >= USABLE) begin
                res.status <= STATUS_FULL;
                done       <= 1'b1;
                state      <= S_IDLE;
              end else begin
                state <= S_HEAD;
              end
            end
            REQ_FILE_SIZE: state <= S_HEAD;
            REQ_LOCATE:    state <= S_HEAD;
          endcase
        end
        S_SCAN: begin
          if (!scan_used) begin
            res.free_entry <= scan_idx;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else if (scan_idx == LAST_ENTRY) begin
            res.status <= STATUS_FULL;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_HEAD: begin
          cur <= tr.dir_data;
          unique case (req_q.req_type)
            REQ_FILE_SIZE: begin
              if (tr.dir_data == END_MARK) begin
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                count <= 8'd1;
                state <= S_WALK;
              end
            end
            REQ_LOCATE: begin
              if (tr.dir_data == END_MARK) begin
                res.status <= STATUS_NO_DATA;
                done       <= 1'b1;
                state      <= S_IDLE;
              end else if (req_q.position == '0) begin
                res.sector_number <= tr.dir_data;
                state             <= S_CALC;
              end else begin
                remain <= req_q.position;
                state  <= S_WALK;
              end
            end
            REQ_APPEND: begin
              if (tr.dir_data == END_MARK) begin
                res.sector_number <= fresh;
                alloc             <= alloc + 1'b1;
                state             <= S_CALC;
              end else begin
                state <= S_WALK;
              end
            end
            REQ_NEW_FILE: state <= S_IDLE;
          endcase
        end
        S_WALK: begin
          if (tr.link_data != END_MARK) begin
            cur <= tr.link_data;
          end
          unique case (req_q.req_type)
            REQ_FILE_SIZE: begin
              if (tr.link_data == END_MARK) begin
                res.size_sectors <= count;
                done             <= 1'b1;
                state            <= S_IDLE;
              end else if (count != END_MARK) begin
                count <= count + 1'b1;
              end
            end
            REQ_LOCATE: begin
              if (tr.link_data == END_MARK) begin
                res.status <= STATUS_NO_DATA;
                done       <= 1'b1;
                state      <= S_IDLE;
              end else if (remain == 8'd1) begin
                res.sector_number <= tr.link_data;
                state             <= S_CALC;
              end else begin
                remain <= remain - 1'b1;
              end
            end
            REQ_APPEND: begin
              if (tr.link_data == END_MARK) begin
                state <= S_TERM;
              end
            end
            REQ_NEW_FILE: state <= S_IDLE;
          endcase
        end
        S_TERM: begin
          res.sector_number <= fresh;
          alloc             <= alloc + 1'b1;
          state             <= S_CALC;
        end
        S_CALC: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (addr_valid) begin
            res.sector_address <= addr;
            done               <= 1'b1;
            state              <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_done_ends_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    alloc <= USABLE)
    else $error("allocation counter passed the usable sectors");

  a_no_sector_no_addr: assert property (@(posedge clk) disable iff (rst)
    (done && result.sector_number == END_MARK) |-> (result.sector_address == '0))
    else $error("address given without a sector");

endmodule

// ===== test/fat_chain_checker.sv =====
// Checker for the write-once file allocation chain engine: watches the request, result and
// register write ports, predicts every result and compares it field by field.
// Depends on wofc_pkg for the item types, request codes and register indexes.
`timescale 1ns / 100ps

module fat_chain_checker
  import wofc_pkg::*;
#(
  parameter int unsigned SECTOR_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  req_t                 req,
  input  logic                 done,
  input  result_t              result,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  localparam int unsigned USABLE_SECTORS = (SECTOR_COUNT > 255) ? 255 : SECTOR_COUNT;
  localparam int unsigned WALK_LIMIT     = 256;
  localparam logic [SECT_W-1:0] SIZE_CAP = 8'd255;

  logic [SECT_W-1:0]  dir_head [DIR_DEPTH];
  logic [SECT_W-1:0]  sector_link [DIR_DEPTH];
  logic [ALLOC_W-1:0] sectors_used;
  logic [ADDR_W-1:0]  base_addr;
  logic [BPS_W-1:0]   sector_bytes;
  result_t            awaited_replies [$];

  function automatic result_t predict_fat_reply(req_t item);
    result_t           reply;
    logic [SECT_W-1:0] cur;
    logic [SECT_W-1:0] fresh;
    logic [8:0]        scan;
    int unsigned       steps;
    reply = RESULT_IDLE;
    cur = dir_head[item.file_number];
    steps = 0;
    case (item.req_type)
      REQ_NEW_FILE: begin
        reply.status = STATUS_FULL;
        for (scan = 0; scan < 9'd255 && reply.status == STATUS_FULL; scan++) begin
          if (dir_head[scan[7:0]] == END_MARK) begin
            reply.status = STATUS_OK;
            reply.free_entry = scan[7:0];
          end
        end
      end
      REQ_FILE_SIZE: begin
        while (cur != END_MARK && steps < WALK_LIMIT) begin
          if (reply.size_sectors != SIZE_CAP) reply.size_sectors++;
          cur = sector_link[cur];
          steps++;
        end
      end
      REQ_APPEND: begin
        if (sectors_used >= USABLE_SECTORS) begin
          reply.status = STATUS_FULL;
        end else begin
          fresh = sectors_used[SECT_W-1:0];
          if (cur == END_MARK) begin
            dir_head[item.file_number] = fresh;
          end else begin
            while (sector_link[cur] != END_MARK && steps < WALK_LIMIT) begin
              cur = sector_link[cur];
              steps++;
            end
            sector_link[cur] = fresh;
          end
          sector_link[fresh] = END_MARK;
          sectors_used++;
          reply.sector_number = fresh;
        end
      end
      REQ_LOCATE: begin
        for (steps = 0; steps < item.position && cur != END_MARK; steps++)
          cur = sector_link[cur];
        if (cur == END_MARK) reply.status = STATUS_NO_DATA;
        else reply.sector_number = cur;
      end
    endcase
    if (reply.sector_number != END_MARK)
      reply.sector_address = base_addr + {24'b0, reply.sector_number} * {15'b0, sector_bytes};
    return reply;
  endfunction

  function automatic int count_field_errors(result_t want, result_t got);
    int errs;
    errs = 0;
    if (got.status !== want.status) begin
      $display("%0t: status mismatch, expected %0d, actual %0d",
               $time, want.status, got.status);
      errs++;
    end
    if (got.free_entry !== want.free_entry) begin
      $display("%0t: free_entry mismatch, expected %0d, actual %0d",
               $time, want.free_entry, got.free_entry);
      errs++;
    end
    if (got.size_sectors !== want.size_sectors) begin
      $display("%0t: size_sectors mismatch, expected %0d, actual %0d",
               $time, want.size_sectors, got.size_sectors);
      errs++;
    end
    if (got.sector_number !== want.sector_number) begin
      $display("%0t: sector_number mismatch, expected %0d, actual %0d",
               $time, want.sector_number, got.sector_number);
      errs++;
    end
    if (got.sector_address !== want.sector_address) begin
      $display("%0t: sector_address mismatch, expected %h, actual %h",
               $time, want.sector_address, got.sector_address);
      errs++;
    end
    return errs;
  endfunction

  always @(posedge clk) begin
    result_t reply;
    int      found;
    found = 0;
    if (rst) begin
      for (int s = 0; s < DIR_DEPTH; s++) begin
        dir_head[s] = END_MARK;
        sector_link[s] = END_MARK;
      end
      sectors_used = '0;
      base_addr = BASE_RESET;
      sector_bytes = BPS_RESET;
      awaited_replies.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_DISK_BASE) base_addr = cfg_data;
        else if (cfg_index == REG_SECTOR_BYTES) sector_bytes = cfg_data[BPS_W-1:0];
      end
      if (done) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: result with no item pending, expected none, actual %h",
                   $time, result);
          found = 1;
        end else begin
          reply = awaited_replies.pop_front();
          found = count_field_errors(reply, result);
        end
      end
      if (start && !busy) awaited_replies.push_back(predict_fat_reply(req));
    end
    mismatches <= rst ? 0 : mismatches + found;
    outstanding <= awaited_replies.size();
  end

endmodule

// ===== test/tb_write_once_fat_chain_engine.sv =====
// Testbench top for the write-once file allocation chain engine: drives directed and random
// requests and register writes, and gives the verdict from the count of fat_chain_checker.
// Depends on wofc_pkg, fat_chain_checker and the engine RTL.
`timescale 1ns / 100ps

module tb_write_once_fat_chain_engine;
  import wofc_pkg::*;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 188;
  localparam int STALL_LIMIT  = 5000;
  localparam int SETTLE_TICKS = 20;
  localparam int REQ_W        = $bits(req_t);

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  req_t                 req;
  logic                 done;
  result_t              result;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;
  int                   mismatches;
  int                   outstanding;
  int                   stall_cycles;
  bit                   rush;

  write_once_fat_chain_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .result(result), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fat_chain_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .result(result), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_wr_en) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic issue_request(input logic [1:0] kind, input logic [SECT_W-1:0] fnum,
                               input logic [SECT_W-1:0] pos);
    start = 1'b1;
    req.req_type = kind;
    req.file_number = fnum;
    req.position = pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(0, 99);
    if (rush || roll < 40) span = 0;
    else if (roll < 85) span = $urandom_range(1, 3);
    else if (roll < 97) span = $urandom_range(4, 15);
    else span = $urandom_range(20, 60);
    if (span != 0) begin
      start = 1'b0;
      repeat (span) begin
        req = REQ_W'($urandom);
        @(negedge clk);
      end
    end
  endtask

  task automatic wait_for_drain();
    start = 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cfg_data = $urandom;
  endtask

  task automatic set_geometry(input logic [ADDR_W-1:0] base, input logic [BPS_W-1:0] bytes);
    wait_for_drain();
    write_register(REG_DISK_BASE, base);
    write_register(REG_SECTOR_BYTES, ($urandom & 32'hFFFE_0000) | {15'b0, bytes});
  endtask

  function automatic logic [SECT_W-1:0] pick_file();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return 8'd1;
    if (roll < 45) return SECT_W'($urandom_range(0, 3));
    if (roll < 80) return SECT_W'($urandom_range(0, 31));
    if (roll < 95) return SECT_W'($urandom_range(0, 255));
    return END_MARK;
  endfunction

  function automatic logic [SECT_W-1:0] pick_position();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return SECT_W'($urandom_range(0, 7));
    if (roll < 80) return SECT_W'($urandom_range(0, 80));
    return SECT_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [1:0] pick_request();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return REQ_NEW_FILE;
    if (roll < 35) return REQ_FILE_SIZE;
    if (roll < 62) return REQ_APPEND;
    return REQ_LOCATE;
  endfunction

  task automatic send(input logic [1:0] kind, input logic [SECT_W-1:0] fnum,
                      input logic [SECT_W-1:0] pos);
    issue_request(kind, fnum, pos);
    idle_gap();
  endtask

  initial begin
    logic [ADDR_W-1:0] base;
    logic [BPS_W-1:0]  bytes;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_DISK_BASE;
    cfg_data = '0;
    rush = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    send(REQ_NEW_FILE, 8'd0, 8'd0);
    send(REQ_FILE_SIZE, 8'd0, 8'd0);
    send(REQ_LOCATE, 8'd0, 8'd0);
    send(REQ_APPEND, 8'd0, 8'd0);
    send(REQ_APPEND, 8'd0, 8'd0);
    send(REQ_APPEND, END_MARK, 8'd0);
    send(REQ_NEW_FILE, 8'd0, 8'd0);
    send(REQ_FILE_SIZE, END_MARK, 8'd0);
    send(REQ_LOCATE, END_MARK, 8'd0);
    send(REQ_APPEND, LAST_ENTRY, 8'd0);
    send(REQ_APPEND, 8'd0, 8'd0);
    send(REQ_FILE_SIZE, 8'd0, 8'd0);
    send(REQ_LOCATE, 8'd0, 8'd2);
    send(REQ_LOCATE, 8'd0, 8'd3);
    send(REQ_LOCATE, 8'd0, 8'd255);
    send(REQ_LOCATE, LAST_ENTRY, 8'd0);
    send(REQ_FILE_SIZE, LAST_ENTRY, 8'd0);
    send(REQ_NEW_FILE, 8'd0, 8'd0);
    set_geometry(32'hFFFF_FFFF, 17'h1_0000);
    send(REQ_LOCATE, 8'd0, 8'd1);
    send(REQ_APPEND, 8'd3, 8'd0);
    send(REQ_LOCATE, END_MARK, 8'd0);
    set_geometry(32'h0000_0000, 17'd1);
    send(REQ_LOCATE, 8'd0, 8'd0);
    send(REQ_APPEND, 8'd3, 8'd0);
    send(REQ_LOCATE, 8'd3, 8'd1);
    send(REQ_FILE_SIZE, 8'd3, 8'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin base = BASE_RESET; bytes = BPS_RESET; end
        1: begin base = $urandom; bytes = BPS_W'($urandom_range(1, 65536)); end
        2: begin base = 32'hFFFF_FFFF; bytes = 17'h1_0000; end
        3: begin base = 32'h0000_0000; bytes = 17'd1; end
        4: begin base = $urandom; bytes = BPS_W'($urandom_range(1, 16)); end
        default: begin base = $urandom; bytes = BPS_W'($urandom_range(1, 65536)); end
      endcase
      rush = (phase == 2);
      set_geometry(base, bytes);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == PHASE_ITEMS / 2) wait_for_drain();
        send(pick_request(), pick_file(), pick_position());
      end
    end

    wait_for_drain();
    repeat (SETTLE_TICKS) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wofc_pkg.sv
rtl/wofc_tables.sv
rtl/wofc_addr.sv
rtl/write_once_fat_chain_engine.sv
test/fat_chain_checker.sv
test/tb_write_once_fat_chain_engine.sv
